// ===== design/dfr_pkg.sv =====
// shared constants and types of the delimited frame receiver
`timescale 1ns / 1ps

package dfr_pkg;

    // message store size, one entry kept free as in the original buffer
    localparam int MSG_SIZE    = 32;
    localparam int STORE_DEPTH = MSG_SIZE - 1;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(MSG_SIZE);

    localparam logic [FILL_W-1:0] MAX_FILL = FILL_W'(STORE_DEPTH);

    // delimiter bytes
    localparam logic [7:0] MARK_OPEN  = 8'h3C;
    localparam logic [7:0] MARK_CLOSE = 8'h3E;
    localparam logic [7:0] MARK_CR    = 8'h0D;

    // message kinds
    localparam logic KIND_TEXT  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    // request from the byte parser to the emit sequencer
    typedef struct packed {
        logic              start;
        logic              kind;
        logic [FILL_W-1:0] count;
    } t_emit_req;

endpackage

// ===== design/dfr_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/dfr_emit.sv =====
// emit sequencer: walks the message store one byte per cycle while the output is ready
`timescale 1ns / 1ps

module dfr_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  dfr_pkg::t_emit_req         i_req,
    output logic                       o_busy,
    output logic                       o_rd_en,
    output logic [dfr_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic                       o_msg_kind,
    output logic [7:0]                 o_data_byte,
    output logic                       o_is_empty,
    output logic                       o_last
);

    logic                       r_valid;
    logic                       r_kind;
    logic                       r_empty;
    logic                       r_last;
    logic [dfr_pkg::FILL_W-1:0] r_left;
    logic [dfr_pkg::ADDR_W-1:0] r_idx;
    logic                       rd_en;

    // ram output register doubles as the data register, so read only when it frees up
    assign rd_en = (r_left != '0) && (!r_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_left  <= '0;
            r_empty <= 1'b0;
            r_last  <= 1'b0;
        end else if (i_req.start) begin
            r_kind <= i_req.kind;
            r_idx  <= '0;
            if (i_req.count == '0) begin
                r_valid <= 1'b1;
                r_empty <= 1'b1;
                r_last  <= 1'b1;
                r_left  <= '0;
            end else begin
                r_empty <= 1'b0;
                r_left  <= i_req.count;
            end
        end else if (rd_en) begin
            r_valid <= 1'b1;
            r_last  <= (r_left == dfr_pkg::FILL_W'(1));
            r_left  <= r_left - dfr_pkg::FILL_W'(1);
            r_idx   <= r_idx + dfr_pkg::ADDR_W'(1);
        end else if (r_valid && i_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_busy      = r_valid || (r_left != '0);
    assign o_rd_en     = rd_en;
    assign o_rd_addr   = r_idx;
    assign o_valid     = r_valid;
    assign o_msg_kind  = r_kind;
    assign o_data_byte = r_empty ? 8'h00 : i_rd_data;
    assign o_is_empty  = r_empty;
    assign o_last      = r_last;

`ifndef SYNTH
    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !o_busy)
        else $error("emit request while a message is still going out");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_empty |-> r_last)
        else $error("empty message result without last");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_ready && r_last |=> !o_busy)
        else $error("sequencer still busy after last transaction");

    a_empty_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start && (i_req.count == '0) |=> r_valid && r_empty)
        else $error("empty message did not raise its single result");
`endif

endmodule

// ===== design/delimited_frame_receiver_top.sv =====
// top level of the delimited frame receiver: byte parser, message store and emit sequencer
`timescale 1ns / 1ps

// Receives bytes one transaction at a time and gathers them into a 31-byte message
// store (a small ram, contents undefined until written, no clearing pass after reset).
// Outside a frame '<' opens a frame, carriage return sends the stored bytes as a text
// line and any other byte is stored; inside a frame '>' sends the bytes as a frame and
// any other byte is stored. A full store sends a text line, or silently drops an open
// frame. Each message comes out as one transaction per byte with o_last on the final
// one; an empty message is a single transaction with o_is_empty set. Bytes are ignored
// while link_enable is 0. A byte that sends nothing leaves o_rx_ready high; a byte that
// sends an n-byte message holds o_rx_ready low until the last output transaction is
// taken. The store has a single read port, walked one address per cycle while the
// output channel is not stalled.
module delimited_frame_receiver_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // received bytes
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    // message bytes out
    output logic       o_msg_valid,
    input  logic       i_msg_ready,
    output logic       o_msg_kind,
    output logic [7:0] o_data_byte,
    output logic       o_is_empty,
    output logic       o_last
);

    logic                       r_link_enable;
    logic                       r_in_frame;
    logic                       n_in_frame;
    logic [dfr_pkg::FILL_W-1:0] r_fill;
    logic [dfr_pkg::FILL_W-1:0] n_fill;

    logic                       rx_accept;
    logic                       busy;
    logic                       wr_en;
    dfr_pkg::t_emit_req         emit_req;
    logic                       rd_en;
    logic [dfr_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                 rd_data;

    // config is always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_enable <= 1'b0;
        end else if (i_cfg_valid) begin
            r_link_enable <= i_cfg_data;
        end
    end

    // hold off new bytes while a message is going out
    assign o_rx_ready = !busy;
    assign rx_accept  = i_rx_valid && o_rx_ready;

    // byte parser: next fill count, frame flag, store write and emit request
    always_comb begin
        n_fill         = r_fill;
        n_in_frame     = r_in_frame;
        wr_en          = 1'b0;
        emit_req.start = 1'b0;
        emit_req.kind  = dfr_pkg::KIND_TEXT;
        emit_req.count = r_fill;
        if (rx_accept && r_link_enable) begin
            if (r_in_frame) begin
                if (i_rx_byte == dfr_pkg::MARK_CLOSE) begin
                    emit_req.start = 1'b1;
                    emit_req.kind  = dfr_pkg::KIND_FRAME;
                    n_fill         = '0;
                    n_in_frame     = 1'b0;
                end else begin
                    wr_en = 1'b1;
                    if (r_fill == dfr_pkg::MAX_FILL - dfr_pkg::FILL_W'(1)) begin
                        // frame overflow: drop it without output
                        n_fill     = '0;
                        n_in_frame = 1'b0;
                    end else begin
                        n_fill = r_fill + dfr_pkg::FILL_W'(1);
                    end
                end
            end else begin
                if (i_rx_byte == dfr_pkg::MARK_OPEN) begin
                    n_fill     = '0;
                    n_in_frame = 1'b1;
                end else if (i_rx_byte == dfr_pkg::MARK_CR) begin
                    emit_req.start = 1'b1;
                    n_fill         = '0;
                end else begin
                    wr_en = 1'b1;
                    if (r_fill == dfr_pkg::MAX_FILL - dfr_pkg::FILL_W'(1)) begin
                        // text overflow: send the full store as a line
                        emit_req.start = 1'b1;
                        emit_req.count = dfr_pkg::MAX_FILL;
                        n_fill         = '0;
                    end else begin
                        n_fill = r_fill + dfr_pkg::FILL_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_in_frame <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_in_frame <= n_in_frame;
        end
    end

    // message store
    dfr_ram #(
        .WIDTH (8),
        .DEPTH (dfr_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_fill[dfr_pkg::ADDR_W-1:0]),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // emit sequencer
    dfr_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (emit_req),
        .o_busy      (busy),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_valid     (o_msg_valid),
        .i_ready     (i_msg_ready),
        .o_msg_kind  (o_msg_kind),
        .o_data_byte (o_data_byte),
        .o_is_empty  (o_is_empty),
        .o_last      (o_last)
    );

endmodule
